// ----- design/lzw_decode_dictionary_unit_defines.svh -----
// Assertion helpers for the dictionary controller RTL.
`ifndef LZW_DECODE_DICTIONARY_UNIT_DEFINES_SVH
`define LZW_DECODE_DICTIONARY_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define LZWDD_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define LZWDD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- design/lzwdd_pkg.sv -----
package lzwdd_pkg;

   localparam int unsigned CODE_W       = 9;
   localparam int unsigned ROOT_W       = 9;
   localparam int unsigned MAXBITS_W    = 4;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 9;
   localparam int unsigned RESULT_LIMIT = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CODE_BITS = 2'd1;

   localparam logic [ROOT_W-1:0]    ROOT_COUNT_RESET    = 9'd256;
   localparam logic [MAXBITS_W-1:0] MAX_CODE_BITS_RESET = 4'd9;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_ADD    = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INIT,
      S_WALK,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0] parent;
      logic [7:0]        value;
   } entry_type;

   typedef struct packed {
      logic [63:0] packed_bytes;
      logic [3:0]  byte_count;
      logic        last;
      status_type  status;
      logic        is_clear_code;
      logic        is_end_code;
      logic [9:0]  entry_count;
      logic [3:0]  code_width;
   } rsp_word_type;

endpackage

// ----- design/lzwdd_entry_ram.sv -----
module lzwdd_entry_ram
   import lzwdd_pkg::*;
#(
   parameter int unsigned ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data_ff
);

   localparam int unsigned DEPTH = 1 << ADDR_W;

   entry_type store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule

// ----- design/lzwdd_out_reg.sv -----
module lzwdd_out_reg
   import lzwdd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         out_load,
   input  rsp_word_type out_word,
   output logic         out_free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign valid_in  = out_load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         word_ff <= out_word;
      end
   end

endmodule

// ----- design/lzwdd_ctrl.sv -----
`include "lzw_decode_dictionary_unit_defines.svh"

module lzwdd_ctrl
   import lzwdd_pkg::*;
#(
   parameter int unsigned MAX_CODE_BITS    = 9,
   parameter int unsigned BYTES_PER_RESULT = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic [CODE_W-1:0]       req_code,
   input  logic [7:0]              req_new_byte,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output logic                    wr_en,
   output logic [MAX_CODE_BITS-1:0] wr_addr,
   output entry_type               wr_data,
   output logic [MAX_CODE_BITS-1:0] rd_addr,
   input  entry_type               rd_data,
   input  logic                    out_free,
   output logic                    out_load,
   output rsp_word_type            out_word
);

   localparam int unsigned AW         = MAX_CODE_BITS;
   localparam int unsigned TW         = AW + 1;
   localparam int unsigned PW         = TW + 1;
   localparam int unsigned WW         = $clog2(AW + 2);
   localparam int unsigned BPR        = BYTES_PER_RESULT;
   localparam int unsigned CW         = $clog2(BPR + 1);
   localparam int unsigned ACC_W      = 8 * BPR;
   localparam int unsigned WALK_LIMIT = RESULT_LIMIT * BPR;
   localparam int unsigned KW         = $clog2(WALK_LIMIT + 1);
   localparam logic [TW-1:0] DEPTH_T  = TW'(1) << AW;

   function automatic logic [4:0] bit_len(input logic [15:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) begin
            n = 5'(i + 1);
         end
      end
      return n;
   endfunction

   state_type            state_ff, state_in;
   logic [ROOT_W-1:0]    root_count_ff;
   logic [MAXBITS_W-1:0] max_bits_ff;
   logic [TW-1:0]        total_ff, total_in;
   logic [WW-1:0]        width_ff, width_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [CODE_W-1:0]    cur_ff, cur_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [KW-1:0]        walked_ff, walked_in;
   logic [TW-1:0]        idx_ff, idx_in;
   logic [TW-1:0]        fill_n_ff, fill_n_in;
   status_type           status_ff, status_in;

   logic [ACC_W-1:0]     emit_acc;
   logic [CW-1:0]        emit_cnt;
   logic                 emit_last;
   status_type           emit_status;
   logic [ACC_W-1:0]     acc_new;
   logic [CW-1:0]        cnt_new;
   logic [9:0]           roots_plus2;
   logic [TW-1:0]        fill_n;
   logic [MAXBITS_W-1:0] bits_clamped;
   logic [TW-1:0]        capacity;
   logic                 full;
   logic [PW-1:0]        width_pow;
   logic [CODE_W-1:0]    parent;

   assign csr_ready = 1'b1;

   // Root fill covers the end and clear codes; clamp to the store depth.
   assign roots_plus2 = {1'b0, root_count_ff} + 10'd2;
   always_comb begin
      if (root_count_ff == '0) begin
         fill_n = '0;
      end else if (TW'(roots_plus2) > DEPTH_T) begin
         fill_n = DEPTH_T;
      end else begin
         fill_n = TW'(roots_plus2);
      end
   end

   assign bits_clamped = (max_bits_ff > MAXBITS_W'(AW)) ? MAXBITS_W'(AW) : max_bits_ff;
   assign capacity     = TW'(1) << bits_clamped;
   assign full         = (total_ff >= capacity) || (total_ff >= DEPTH_T);
   assign width_pow    = PW'(1) << width_ff;
   assign parent       = rd_data.parent;

   always_comb begin
      acc_new = acc_ff;
      for (int i = 0; i < BPR; i++) begin
         if (cnt_ff == CW'(i)) begin
            acc_new[8*i +: 8] = rd_data.value;
         end
      end
      cnt_new = cnt_ff + CW'(1);
   end

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      width_in    = width_ff;
      code_in     = code_ff;
      cur_in      = cur_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      walked_in   = walked_ff;
      idx_in      = idx_ff;
      fill_n_in   = fill_n_ff;
      status_in   = status_ff;
      req_stall   = 1'b1;
      wr_en       = 1'b0;
      wr_addr     = AW'(idx_ff);
      wr_data     = '{parent: CODE_W'(idx_ff), value: idx_ff[7:0]};
      rd_addr     = AW'(cur_ff);
      out_load    = 1'b0;
      emit_acc    = acc_ff;
      emit_cnt    = cnt_ff;
      emit_last   = 1'b1;
      emit_status = status_ff;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               code_in   = req_code;
               acc_in    = '0;
               cnt_in    = '0;
               walked_in = '0;
               status_in = ST_OK;
               state_in  = S_FIN;
               case (op_type'(req_operation))
                  OP_INIT: begin
                     fill_n_in = fill_n;
                     idx_in    = '0;
                     state_in  = S_INIT;
                  end
                  OP_ADD: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(total_ff);
                        wr_data  = '{parent: req_code, value: req_new_byte};
                        total_in = total_ff + TW'(1);
                        if ({1'b0, total_ff} >= width_pow - PW'(1)) begin
                           width_in = width_ff + WW'(1);
                        end
                     end
                  end
                  OP_LOOKUP: begin
                     if (TW'(req_code) >= total_ff) begin
                        status_in = ST_UNKNOWN;
                     end else begin
                        rd_addr  = AW'(req_code);
                        cur_in   = req_code;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_INIT: begin
            if (idx_ff == fill_n_ff) begin
               total_in  = fill_n_ff;
               width_in  = WW'(bit_len(16'(fill_n_ff)));
               state_in  = S_FIN;
            end else begin
               // Only entries below 512 are reachable, so a 9-bit self pointer suffices.
               wr_en  = 1'b1;
               idx_in = idx_ff + TW'(1);
            end
         end

         S_WALK: begin
            // rd_data holds the entry of cur_ff; hold everything while the output is busy.
            if (out_free) begin
               if (walked_ff == KW'(WALK_LIMIT)) begin
                  out_load    = 1'b1;
                  emit_status = ST_UNKNOWN;
                  state_in    = S_IDLE;
               end else if (cnt_ff == CW'(BPR)) begin
                  out_load    = 1'b1;
                  emit_last   = 1'b0;
                  emit_status = ST_OK;
                  acc_in      = '0;
                  cnt_in      = '0;
               end else begin
                  acc_in    = acc_new;
                  cnt_in    = cnt_new;
                  walked_in = walked_ff + KW'(1);
                  emit_acc  = acc_new;
                  emit_cnt  = cnt_new;
                  if (parent == cur_ff) begin
                     out_load    = 1'b1;
                     emit_status = ST_OK;
                     state_in    = S_IDLE;
                  end else if (TW'(parent) >= total_ff) begin
                     out_load    = 1'b1;
                     emit_status = ST_UNKNOWN;
                     state_in    = S_IDLE;
                  end else begin
                     cur_in  = parent;
                     rd_addr = AW'(parent);
                  end
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_word.packed_bytes  = 64'(emit_acc);
      out_word.byte_count    = 4'(emit_cnt);
      out_word.last          = emit_last;
      out_word.status        = emit_status;
      out_word.is_clear_code = ({1'b0, code_ff} == ({1'b0, root_count_ff} + 10'd1));
      out_word.is_end_code   = (code_ff == root_count_ff);
      out_word.entry_count   = 10'(total_ff);
      out_word.code_width    = 4'(width_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_count_ff <= ROOT_COUNT_RESET;
         max_bits_ff   <= MAX_CODE_BITS_RESET;
         total_ff      <= '0;
         width_ff      <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         width_ff <= width_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROOT_COUNT:    root_count_ff <= csr_data[ROOT_W-1:0];
               CSR_MAX_CODE_BITS: max_bits_ff   <= csr_data[MAXBITS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      cur_ff    <= cur_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      walked_ff <= walked_in;
      idx_ff    <= idx_in;
      fill_n_ff <= fill_n_in;
      status_ff <= status_in;
   end

   `LZWDD_ASSERT_IMPLY(a_load_when_free, out_load, out_free, "result loaded into busy output")
   `LZWDD_ASSERT_ALWAYS(a_total_in_range, total_ff <= DEPTH_T, "entry total beyond store depth")
   `LZWDD_ASSERT_IMPLY(a_cnt_in_range, state_ff == S_WALK, cnt_ff <= CW'(BPR), "byte count overrun")
   `LZWDD_ASSERT_IMPLY(a_width_tracks_total, state_ff == S_IDLE, 5'(width_ff) == bit_len(16'(total_ff)), "code width out of step with entry total")

endmodule

// ----- design/lzw_decode_dictionary_unit.sv -----
// LZW decoding dictionary.
// Input channel req_*: one word per operation (initialize roots, add entry, look up
// string, no operation), accepted when req_valid is high and req_stall is low.
// Result channel rsp_*: initialize, add and no operation give one word; a lookup gives
// one word per BYTES_PER_RESULT string bytes, rsp_last marks the final one.
// Configuration port csr_*: always ready; write root_count and max_code_bits only while
// the block is idle.
// Entries live in one synchronous RAM of 2^MAX_CODE_BITS entries, one read a cycle.
// Add and no operation pass through the finish state to the output register; initialize
// first writes one RAM entry per root plus the end and clear codes. Lookup walks the
// parent chain through the RAM read port at one entry per cycle, except while a filled
// result word is emitted or the output register is busy. A new word is taken as soon as
// the previous operation has handed its last result to the output register.
// A stalled receiver freezes the output register and, once that is full, the walk.
// Reset empties the dictionary (entry count and code width zero) and restores
// root_count 256 and max_code_bits 9; RAM contents are undefined until initialized.
module lzw_decode_dictionary_unit
   import lzwdd_pkg::*;
#(
   parameter int unsigned MAX_CODE_BITS    = 9,
   parameter int unsigned BYTES_PER_RESULT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [CODE_W-1:0]      req_code,
   input  logic [7:0]             req_new_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_packed_bytes,
   output logic [3:0]             rsp_byte_count,
   output logic                   rsp_last,
   output logic [1:0]             rsp_status,
   output logic                   rsp_is_clear_code,
   output logic                   rsp_is_end_code,
   output logic [9:0]             rsp_entry_count,
   output logic [3:0]             rsp_code_width,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic                     wr_en;
   logic [MAX_CODE_BITS-1:0] wr_addr;
   entry_type                wr_data;
   logic [MAX_CODE_BITS-1:0] rd_addr;
   entry_type                rd_data;
   logic                     out_free;
   logic                     out_load;
   rsp_word_type             out_word;
   rsp_word_type             rsp_word;

   lzwdd_ctrl #(
      .MAX_CODE_BITS    (MAX_CODE_BITS),
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_code      (req_code),
      .req_new_byte  (req_new_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .out_free      (out_free),
      .out_load      (out_load),
      .out_word      (out_word)
   );

   lzwdd_entry_ram #(
      .ADDR_W (MAX_CODE_BITS)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   lzwdd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .out_load  (out_load),
      .out_word  (out_word),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_packed_bytes  = rsp_word.packed_bytes;
   assign rsp_byte_count    = rsp_word.byte_count;
   assign rsp_last          = rsp_word.last;
   assign rsp_status        = rsp_word.status;
   assign rsp_is_clear_code = rsp_word.is_clear_code;
   assign rsp_is_end_code   = rsp_word.is_end_code;
   assign rsp_entry_count   = rsp_word.entry_count;
   assign rsp_code_width    = rsp_word.code_width;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
   import lzwdd_pkg::*;

   localparam int unsigned STORE_DEPTH   = 512;
   localparam int unsigned BYTES_PER_RSP = 8;
   localparam int unsigned WALK_LIMIT    = RESULT_LIMIT * BYTES_PER_RSP;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned TAIL_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_operation = OP_NOP;
   logic [CODE_W-1:0]      req_code = '0;
   logic [7:0]             req_new_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [63:0]            rsp_packed_bytes;
   logic [3:0]             rsp_byte_count;
   logic                   rsp_last;
   logic [1:0]             rsp_status;
   logic                   rsp_is_clear_code;
   logic                   rsp_is_end_code;
   logic [9:0]             rsp_entry_count;
   logic [3:0]             rsp_code_width;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ROOT_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // dictionary mirror and register copies
   logic [CODE_W-1:0] dict_parent [STORE_DEPTH];
   logic [7:0]        dict_byte [STORE_DEPTH];
   int unsigned       dict_total = 0;
   int unsigned       dict_width = 0;
   int unsigned       cfg_roots = ROOT_COUNT_RESET;
   int unsigned       cfg_max_bits = MAX_CODE_BITS_RESET;

   rsp_word_type expected_words [$];
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   int unsigned  hold_asks = 0;
   int unsigned  hold_seen = 0;
   int unsigned  hold_left = 0;

   lzw_decode_dictionary_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_code          (req_code),
      .req_new_byte      (req_new_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_packed_bytes  (rsp_packed_bytes),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status),
      .rsp_is_clear_code (rsp_is_clear_code),
      .rsp_is_end_code   (rsp_is_end_code),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_code_width    (rsp_code_width),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic void queue_word(logic [63:0] bytes, int unsigned cnt, logic is_last,
                                      status_type st, logic [CODE_W-1:0] code);
      rsp_word_type w;
      w.packed_bytes  = bytes;
      w.byte_count    = 4'(cnt);
      w.last          = is_last;
      w.status        = st;
      w.is_clear_code = (code == cfg_roots + 1);
      w.is_end_code   = (code == cfg_roots);
      w.entry_count   = 10'(dict_total);
      w.code_width    = 4'(dict_width);
      expected_words.push_back(w);
   endfunction

   function automatic void predict_dictionary(op_type op, logic [CODE_W-1:0] code,
                                              logic [7:0] nb);
      int unsigned n, bits, cur, walked, cnt, i;
      logic [63:0] acc;
      status_type  st;
      case (op)
         OP_INIT: begin
            n = (cfg_roots == 0) ? 0 : cfg_roots + 2;
            if (n > STORE_DEPTH) n = STORE_DEPTH;
            for (i = 0; i < n; i++) begin
               dict_parent[i] = CODE_W'(i);
               dict_byte[i] = 8'(i);
            end
            dict_total = n;
            dict_width = $clog2(n + 1);
            queue_word('0, 0, 1'b1, ST_OK, code);
         end
         OP_ADD: begin
            bits = (cfg_max_bits > 9) ? 9 : cfg_max_bits;
            if (dict_total >= (1 << bits) || dict_total >= STORE_DEPTH) begin
               queue_word('0, 0, 1'b1, ST_FULL, code);
            end else begin
               dict_parent[dict_total] = code;
               dict_byte[dict_total] = nb;
               if (dict_total >= (1 << dict_width) - 1) dict_width++;
               dict_total++;
               queue_word('0, 0, 1'b1, ST_OK, code);
            end
         end
         OP_LOOKUP: begin
            cur = code;
            walked = 0;
            cnt = 0;
            acc = '0;
            st = ST_OK;
            forever begin
               if (cur >= dict_total || cur >= STORE_DEPTH || walked >= WALK_LIMIT) begin
                  st = ST_UNKNOWN;
                  break;
               end
               if (cnt == BYTES_PER_RSP) begin
                  queue_word(acc, cnt, 1'b0, ST_OK, code);
                  acc = '0;
                  cnt = 0;
               end
               acc |= 64'(dict_byte[cur]) << (8 * cnt);
               cnt++;
               walked++;
               if (dict_parent[cur] == cur) break;
               cur = dict_parent[cur];
            end
            queue_word(acc, cnt, 1'b1, st, code);
         end
         default: queue_word('0, 0, 1'b1, ST_OK, code);
      endcase
   endfunction

   function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: result word with none expected, expected nothing, actual bytes %0h",
                     $time, rsp_packed_bytes);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            compare_field("packed_bytes", want.packed_bytes, rsp_packed_bytes);
            compare_field("byte_count", want.byte_count, rsp_byte_count);
            compare_field("last", want.last, rsp_last);
            compare_field("status", want.status, rsp_status);
            compare_field("is_clear_code", want.is_clear_code, rsp_is_clear_code);
            compare_field("is_end_code", want.is_end_code, rsp_is_end_code);
            compare_field("entry_count", want.entry_count, rsp_entry_count);
            compare_field("code_width", want.code_width, rsp_code_width);
         end
      end
   end

   // hold the word until taken; valid stays high so back-to-back words need no re-raise
   task automatic send_word(op_type op, logic [CODE_W-1:0] code, logic [7:0] nb);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_code      <= code;
      req_new_byte  <= nb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_dictionary(op, code, nb);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(logic [8:0] roots, logic [3:0] bits);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROOT_COUNT;
      csr_data  <= CSR_DATA_W'(roots);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_roots = roots;
      csr_index <= CSR_MAX_CODE_BITS;
      csr_data  <= CSR_DATA_W'(bits);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_max_bits = bits;
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_dictionary();
      send_word(OP_LOOKUP, 9'd0, 8'h00);
      // parent points past the table, so the walk stops after one byte
      send_word(OP_ADD, 9'h1FF, 8'hFF);
      send_word(OP_LOOKUP, 9'd0, 8'h00);
   endtask

   task automatic test_root_entries();
      send_word(OP_INIT, 9'd256, 8'h00);
      send_word(OP_LOOKUP, 9'd0, 8'h00);
      send_word(OP_LOOKUP, 9'd255, 8'h00);
      send_word(OP_LOOKUP, 9'd257, 8'h00);
      send_word(OP_LOOKUP, 9'd258, 8'h00);
      send_word(OP_NOP, 9'd256, 8'h00);
   endtask

   task automatic test_string_chains();
      int unsigned i, tip;
      send_word(OP_ADD, 9'd65, 8'h42);
      send_word(OP_ADD, 9'd258, 8'h43);
      send_word(OP_LOOKUP, 9'd259, 8'h00);
      for (i = 0; i < 6; i++) send_word(OP_ADD, 9'(259 + i), 8'(8'h80 + i));
      send_word(OP_LOOKUP, 9'd265, 8'h00);
      // two entries pointing at each other: walk runs to its length limit
      tip = dict_total;
      send_word(OP_ADD, 9'(tip + 1), 8'h5A);
      send_word(OP_ADD, 9'(tip), 8'hA5);
      send_word(OP_LOOKUP, 9'(tip), 8'h00);
   endtask

   task automatic test_output_backpressure();
      int unsigned i;
      send_idle_pct = 0;
      hold_asks <= hold_asks + 1;
      for (i = 0; i < 10; i++) begin
         if (i % 3 == 2) send_word(OP_ADD, 9'd265, 8'(i));
         else send_word(OP_LOOKUP, 9'd265, 8'h00);
      end
      drain();
   endtask

   task automatic test_capacity_limits();
      drain();
      set_config(9'd2, 4'd2);
      send_word(OP_INIT, 9'd3, 8'h00);
      send_word(OP_ADD, 9'd0, 8'h01);
      send_word(OP_LOOKUP, 9'd3, 8'h00);
      drain();
      // more roots than capacity: roots still filled, every add full
      set_config(9'd256, 4'd2);
      send_word(OP_INIT, 9'd0, 8'h00);
      send_word(OP_ADD, 9'd1, 8'h7F);
      drain();
   endtask

   task automatic test_random_traffic();
      logic [8:0]  roots_list [8] = '{9'd256, 9'd2, 9'd2, 9'd256, 9'd130, 9'd255, 9'd3, 9'd64};
      logic [3:0]  bits_list [8]  = '{4'd9, 4'd2, 4'd9, 4'd8, 4'd5, 4'd9, 4'd3, 4'd7};
      int unsigned send_list [4]  = '{0, 63, 0, 14};
      int unsigned stall_list [4] = '{0, 0, 63, 14};
      int unsigned mode, j, k, pick;
      logic [CODE_W-1:0] c;
      for (mode = 0; mode < 4; mode++) begin
         for (j = 0; j < 2; j++) begin
            drain();
            send_idle_pct = send_list[mode];
            rsp_stall_pct = stall_list[mode];
            set_config(roots_list[2 * mode + j], bits_list[2 * mode + j]);
            send_word(OP_INIT, 9'($urandom_range(511)), 8'($urandom_range(255)));
            for (k = 0; k < 23; k++) begin
               pick = $urandom_range(99);
               if (pick < 40) begin
                  // half the time extend the newest string, as a real decoder does
                  if (dict_total == 0) c = 9'($urandom_range(511));
                  else if ($urandom_range(1)) c = 9'(dict_total - 1);
                  else c = 9'($urandom_range(dict_total - 1));
                  send_word(OP_ADD, c, 8'($urandom_range(255)));
               end else if (pick < 78) begin
                  if (dict_total == 0) c = 9'($urandom_range(511));
                  else if ($urandom_range(3) == 0) c = 9'(dict_total - 1);
                  else c = 9'($urandom_range(dict_total - 1));
                  send_word(OP_LOOKUP, c, 8'($urandom_range(255)));
               end else if (pick < 86) begin
                  send_word(OP_LOOKUP, 9'($urandom_range(511)), 8'($urandom_range(255)));
               end else if (pick < 92) begin
                  send_word(OP_ADD, 9'($urandom_range(511)), 8'($urandom_range(255)));
               end else if (pick < 96) begin
                  send_word(OP_NOP, 9'($urandom_range(511)), 8'($urandom_range(255)));
               end else begin
                  send_word(OP_INIT, 9'($urandom_range(511)), 8'($urandom_range(255)));
               end
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 14;
      rsp_stall_pct = 14;
      test_empty_dictionary();
      test_root_entries();
      test_string_chains();
      test_output_backpressure();
      test_capacity_limits();
      test_random_traffic();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/lzwdd_pkg.sv
design/lzwdd_entry_ram.sv
design/lzwdd_out_reg.sv
design/lzwdd_ctrl.sv
design/lzw_decode_dictionary_unit.sv
dv/tb_top.sv
